[rtl/core/uv_sphere_mesh_generator_top_macros.svh]
// ----------------------------------------------------------------------------
// UV sphere mesh generator assertion macros
// Shorthand for clocked checks with reset disable, same cycle and next cycle.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_MESH_GENERATOR_TOP_MACROS_SVH
`define UV_SPHERE_MESH_GENERATOR_TOP_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define UVS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("uvs check failed");

// The condition must hold in the cycle after the trigger.
`define UVS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("uvs check failed");

`endif

[rtl/core/uvs_pkg.sv]
// ----------------------------------------------------------------------------
// UV sphere mesh generator package
// Shared widths, register codes, polynomial constants and pipeline types.
// ----------------------------------------------------------------------------
`default_nettype none

package uvs_pkg;

	localparam int MAX_SECTORS = 256;
	localparam int MAX_STACKS  = 256;

	localparam int IDX_W   = 9;
	localparam int CFG_W   = 16;
	localparam int COORD_W = 17;
	localparam int VIDX_W  = 17;
	localparam int NUM_W   = 26;
	localparam int DIV_STEPS = 17;

	localparam logic [15:0] RADIUS_RST  = 16'd256;
	localparam logic [8:0]  SECTORS_RST = 9'd36;
	localparam logic [8:0]  STACKS_RST  = 9'd18;

	localparam logic [31:0] C1 = 32'd1686629713;
	localparam logic [31:0] C3 = 32'd693598668;
	localparam logic [31:0] C5 = 32'd85569306;
	localparam logic [31:0] C7 = 32'd5026995;
	localparam logic [31:0] C9 = 32'd172272;

	localparam logic [15:0] QUARTER_TURN = 16'd16384;

	typedef enum logic [1:0] {
		REG_RADIUS  = 2'd0,
		REG_SECTORS = 2'd1,
		REG_STACKS  = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_VERTEX = 1'b0,
		OP_CELL   = 1'b1
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             oor;
		logic             top;
		logic             bot;
		logic [16:0]      k1;
		logic [16:0]      k2;
		logic [8:0]       rem_u;
		logic [8:0]       rem_v;
		logic [16:0]      num_u;
		logic [16:0]      num_v;
		logic [16:0]      q_u;
		logic [16:0]      q_v;
		logic [3:0][14:0] xq;
		logic [3:0]       ng;
		logic [3:0][30:0] t2;
		logic [3:0][31:0] p;
		logic [3:0][31:0] sv;
		logic [3:0][15:0] sn;
		logic [16:0]      xy;
		logic [16:0]      z;
		logic [16:0]      x;
		logic [16:0]      y;
	} pipe_t;

	// Magnitude-sign product with symmetric half-up rounding, scaled by 2^-15.
	function automatic logic [16:0] fx_mul(input logic [15:0] am, input logic an,
		input logic [15:0] s);
		logic        sneg;
		logic [15:0] sm;
		logic [31:0] prod;
		logic [16:0] m;
		sneg = s[15];
		sm = sneg ? 16'(-s) : s;
		prod = 32'(am) * 32'(sm) + 32'd16384;
		m = {1'b0, prod[30:15]};
		return (an ^ sneg) ? 17'(-m) : m;
	endfunction

endpackage

`default_nettype wire

[rtl/core/uvs_if.sv]
// ----------------------------------------------------------------------------
// UV sphere mesh generator channels
// Request and result channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface uvs_req_if;
	import uvs_pkg::*;

	logic             valid;
	logic             ready;
	logic             operation;
	logic [IDX_W-1:0] stack_index;
	logic [IDX_W-1:0] sector_index;

	modport source (output valid, operation, stack_index, sector_index, input ready);
	modport sink (input valid, operation, stack_index, sector_index, output ready);
endinterface

interface uvs_res_if;
	import uvs_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [COORD_W-1:0] pos_z;
	logic [VIDX_W-1:0]         corner_a;
	logic [VIDX_W-1:0]         corner_b;
	logic [VIDX_W-1:0]         corner_c;
	logic                      last_of_run;
	logic                      out_of_range;

	modport source (output valid, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c,
		last_of_run, out_of_range, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c,
		last_of_run, out_of_range, output ready);
endinterface

`default_nettype wire

[rtl/core/uv_sphere_mesh_generator_top.sv]
// An item passes stage 0, the 17 stage divider and the sine and scaling stages.
// One item is accepted per cycle unless the result channel or a cell with two
// triangles stalls the pipeline; such a cell holds the output for both results.
// Reset clears all valid bits and the output valid and select flags and loads
// the register defaults radius 256, 36 sectors and 18 stacks.
// ----------------------------------------------------------------------------
// UV sphere mesh generator
// Pipelined vertex positions and cell triangles of a latitude/longitude grid.
// ----------------------------------------------------------------------------
`default_nettype none

module uv_sphere_mesh_generator_top (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [1:0]               cfg_index,
	input  wire logic [uvs_pkg::CFG_W-1:0] cfg_wdata,
	uvs_req_if.sink                       req,
	uvs_res_if.source                     res
);
	import uvs_pkg::*;

	localparam int S_T2   = 1 + DIV_STEPS;
	localparam int S_H0   = S_T2 + 1;
	localparam int S_SM   = S_H0 + 4;
	localparam int S_RND  = S_SM + 1;
	localparam int S_RZ   = S_RND + 1;
	localparam int S_XY   = S_RZ + 1;
	localparam int NSTG   = S_XY + 1;

	logic [15:0] radius_q;
	logic [8:0]  sector_count_q;
	logic [8:0]  stack_count_q;
	logic [8:0]  sec_c;
	logic [8:0]  stk_c;

	pipe_t            pipe_s [NSTG];
	pipe_t            nxt [NSTG];
	logic [NSTG-1:0]  vld_s;
	logic [NSTG-1:0]  en;

	logic        out_v_q;
	logic        sel_q;
	op_t         op_q;
	logic        oor_q;
	logic        bot_q;
	logic [16:0] k1_q;
	logic [16:0] k2_q;
	logic [16:0] px_q;
	logic [16:0] py_q;
	logic [16:0] pz_q;
	logic        out_last;
	logic        out_free;
	logic        cell_ok;
	logic        vert_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			sector_count_q <= SECTORS_RST;
			stack_count_q <= STACKS_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RADIUS:  radius_q <= cfg_wdata;
				REG_SECTORS: sector_count_q <= cfg_wdata[8:0];
				REG_STACKS:  stack_count_q <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (sector_count_q < 9'd3) begin
			sec_c = 9'd3;
		end else if (11'(sector_count_q) > 11'(MAX_SECTORS)) begin
			sec_c = 9'(MAX_SECTORS);
		end else begin
			sec_c = sector_count_q;
		end
		if (stack_count_q < 9'd2) begin
			stk_c = 9'd2;
		end else if (11'(stack_count_q) > 11'(MAX_STACKS)) begin
			stk_c = 9'(MAX_STACKS);
		end else begin
			stk_c = stack_count_q;
		end
	end

	// Stage 0: range check, row flags, cell indices and divider numerators.
	always_comb begin
		logic [8:0]       i;
		logic [8:0]       j;
		logic [18:0]      k1w;
		logic [NUM_W-1:0] nu;
		logic [NUM_W-1:0] nv;
		i = req.stack_index;
		j = req.sector_index;
		nxt[0] = '0;
		nxt[0].op = op_t'(req.operation);
		if (op_t'(req.operation) == OP_CELL) begin
			nxt[0].oor = (i >= stk_c) || (j >= sec_c);
		end else begin
			nxt[0].oor = (i > stk_c) || (j > sec_c);
		end
		nxt[0].top = (i != 9'd0);
		nxt[0].bot = (i != 9'(stk_c - 9'd1));
		k1w = 19'(i) * 19'(sec_c) + 19'(i) + 19'(j);
		nxt[0].k1 = k1w[16:0];
		nxt[0].k2 = 17'(k1w + 19'(sec_c) + 19'd1);
		nu = (NUM_W'(i) << 15) + NUM_W'(stk_c >> 1);
		nv = (NUM_W'(j) << 16) + NUM_W'(sec_c >> 1);
		nxt[0].rem_u = nu[NUM_W-1:DIV_STEPS];
		nxt[0].rem_v = nv[NUM_W-1:DIV_STEPS];
		nxt[0].num_u = nu[DIV_STEPS-1:0];
		nxt[0].num_v = nv[DIV_STEPS-1:0];
	end

	// Restoring division, one quotient bit per stage for both angles.
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		always_comb begin
			logic [9:0] shu;
			logic [9:0] shv;
			nxt[k] = pipe_s[k-1];
			shu = {pipe_s[k-1].rem_u, pipe_s[k-1].num_u[16]};
			shv = {pipe_s[k-1].rem_v, pipe_s[k-1].num_v[16]};
			nxt[k].num_u = pipe_s[k-1].num_u << 1;
			nxt[k].num_v = pipe_s[k-1].num_v << 1;
			if (shu >= {1'b0, stk_c}) begin
				nxt[k].rem_u = 9'(shu - {1'b0, stk_c});
				nxt[k].q_u = {pipe_s[k-1].q_u[15:0], 1'b1};
			end else begin
				nxt[k].rem_u = shu[8:0];
				nxt[k].q_u = {pipe_s[k-1].q_u[15:0], 1'b0};
			end
			if (shv >= {1'b0, sec_c}) begin
				nxt[k].rem_v = 9'(shv - {1'b0, sec_c});
				nxt[k].q_v = {pipe_s[k-1].q_v[15:0], 1'b1};
			end else begin
				nxt[k].rem_v = shv[8:0];
				nxt[k].q_v = {pipe_s[k-1].q_v[15:0], 1'b0};
			end
		end
	end

	// Phases, quadrant folding and the squared argument of each sine lane.
	// Lanes: cos(u), sin(u), cos(v), sin(v).
	always_comb begin
		logic [15:0]      pu;
		logic [15:0]      pv;
		logic [3:0][15:0] ph;
		logic [29:0]      xx;
		nxt[S_T2] = pipe_s[S_T2-1];
		pu = 16'(QUARTER_TURN - pipe_s[S_T2-1].q_u[15:0]);
		pv = pipe_s[S_T2-1].q_v[15:0];
		ph[0] = 16'(pu + QUARTER_TURN);
		ph[1] = pu;
		ph[2] = 16'(pv + QUARTER_TURN);
		ph[3] = pv;
		for (int l = 0; l < 4; l++) begin
			if (ph[l][14]) begin
				nxt[S_T2].xq[l] = 15'(16'(QUARTER_TURN) - {2'b00, ph[l][13:0]});
			end else begin
				nxt[S_T2].xq[l] = {1'b0, ph[l][13:0]};
			end
			nxt[S_T2].ng[l] = ph[l][15];
			xx = 30'(nxt[S_T2].xq[l]) * 30'(nxt[S_T2].xq[l]);
			nxt[S_T2].t2[l] = {xx[28:0], 2'b00};
		end
	end

	// Horner steps of the odd polynomial, one product per stage.
	for (genvar h = 0; h < 4; h++) begin : g_horner
		localparam logic [31:0] COEF = (h == 0) ? C7 : (h == 1) ? C5 : (h == 2) ? C3 : C1;
		always_comb begin
			logic [62:0] prod;
			logic [31:0] pin;
			nxt[S_H0+h] = pipe_s[S_H0+h-1];
			for (int l = 0; l < 4; l++) begin
				pin = (h == 0) ? C9 : pipe_s[S_H0+h-1].p[l];
				prod = 63'(pin) * 63'(pipe_s[S_H0+h-1].t2[l]);
				nxt[S_H0+h].p[l] = COEF - prod[61:30];
			end
		end
	end

	always_comb begin
		logic [46:0] prod;
		nxt[S_SM] = pipe_s[S_SM-1];
		for (int l = 0; l < 4; l++) begin
			prod = 47'(pipe_s[S_SM-1].p[l]) * 47'(pipe_s[S_SM-1].xq[l]);
			nxt[S_SM].sv[l] = prod[45:14];
		end
	end

	always_comb begin
		logic [32:0] r;
		logic [14:0] mag;
		nxt[S_RND] = pipe_s[S_RND-1];
		for (int l = 0; l < 4; l++) begin
			r = 33'(pipe_s[S_RND-1].sv[l]) + 33'd16384;
			mag = (r[32:15] > 18'd32767) ? 15'h7fff : r[29:15];
			nxt[S_RND].sn[l] = pipe_s[S_RND-1].ng[l] ? -{1'b0, mag} : {1'b0, mag};
		end
	end

	always_comb begin
		nxt[S_RZ] = pipe_s[S_RZ-1];
		nxt[S_RZ].xy = fx_mul(radius_q, 1'b0, pipe_s[S_RZ-1].sn[0]);
		nxt[S_RZ].z = fx_mul(radius_q, 1'b0, pipe_s[S_RZ-1].sn[1]);
	end

	always_comb begin
		logic [16:0] am;
		nxt[S_XY] = pipe_s[S_XY-1];
		am = pipe_s[S_XY-1].xy[16] ? 17'(-pipe_s[S_XY-1].xy) : pipe_s[S_XY-1].xy;
		nxt[S_XY].x = fx_mul(am[15:0], pipe_s[S_XY-1].xy[16], pipe_s[S_XY-1].sn[2]);
		nxt[S_XY].y = fx_mul(am[15:0], pipe_s[S_XY-1].xy[16], pipe_s[S_XY-1].sn[3]);
	end

	// A stage loads when it is empty or when its content moves on.
	assign en[NSTG-1] = !vld_s[NSTG-1] || out_free;
	for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
		assign en[k] = !vld_s[k] || en[k+1];
	end

	for (genvar k = 0; k < NSTG; k++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en[k]) begin
				pipe_s[k] <= nxt[k];
			end
		end

		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[0] <= 1'b0;
				end else if (en[0]) begin
					vld_s[0] <= req.valid;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign req.ready = en[0];

	// Output register; a cell with two triangles stays for a second result.
	assign out_last = oor_q || (op_q == OP_VERTEX) || sel_q || !bot_q;
	assign out_free = !out_v_q || (res.ready && out_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sel_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= vld_s[NSTG-1];
			sel_q <= !pipe_s[NSTG-1].top;
		end else if (res.ready) begin
			sel_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			op_q <= pipe_s[NSTG-1].op;
			oor_q <= pipe_s[NSTG-1].oor;
			bot_q <= pipe_s[NSTG-1].bot;
			k1_q <= pipe_s[NSTG-1].k1;
			k2_q <= pipe_s[NSTG-1].k2;
			px_q <= pipe_s[NSTG-1].x;
			py_q <= pipe_s[NSTG-1].y;
			pz_q <= pipe_s[NSTG-1].z;
		end
	end

	assign cell_ok = (op_q == OP_CELL) && !oor_q;
	assign vert_ok = (op_q == OP_VERTEX) && !oor_q;

	assign res.valid = out_v_q;
	assign res.pos_x = vert_ok ? px_q : '0;
	assign res.pos_y = vert_ok ? py_q : '0;
	assign res.pos_z = vert_ok ? pz_q : '0;
	assign res.corner_a = cell_ok ? (sel_q ? 17'(k1_q + 17'd1) : k1_q) : '0;
	assign res.corner_b = cell_ok ? k2_q : '0;
	assign res.corner_c = cell_ok ? (sel_q ? 17'(k2_q + 17'd1) : 17'(k1_q + 17'd1)) : '0;
	assign res.last_of_run = out_last;
	assign res.out_of_range = oor_q;

endmodule

`default_nettype wire

[rtl/core/uvs_checker.sv]
// ----------------------------------------------------------------------------
// UV sphere mesh generator checker
// Port level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uv_sphere_mesh_generator_top_macros.svh"

module uvs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [16:0] pos_x,
	input wire logic [16:0] pos_y,
	input wire logic [16:0] pos_z,
	input wire logic [16:0] corner_a,
	input wire logic [16:0] corner_b,
	input wire logic [16:0] corner_c,
	input wire logic        last_of_run,
	input wire logic        out_of_range
);

	`UVS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)

	`UVS_ASSERT_NOW(a_oor_zero, out_valid && out_of_range,
		last_of_run && pos_x == 17'd0 && pos_y == 17'd0 && pos_z == 17'd0 &&
		corner_a == 17'd0 && corner_b == 17'd0 && corner_c == 17'd0)

	`UVS_ASSERT_NOW(a_first_tri, out_valid && !last_of_run,
		!out_of_range && pos_x == 17'd0 && pos_y == 17'd0 && pos_z == 17'd0 &&
		corner_c == 17'(corner_a + 17'd1))

	`UVS_ASSERT_NEXT(a_second_tri, out_valid && out_ready && !last_of_run,
		out_valid && last_of_run && $stable(corner_b) && corner_a == $past(corner_c))

endmodule

bind uv_sphere_mesh_generator_top uvs_checker u_uvs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(res.valid),
	.out_ready(res.ready),
	.pos_x(res.pos_x),
	.pos_y(res.pos_y),
	.pos_z(res.pos_z),
	.corner_a(res.corner_a),
	.corner_b(res.corner_b),
	.corner_c(res.corner_c),
	.last_of_run(res.last_of_run),
	.out_of_range(res.out_of_range)
);

`default_nettype wire
